/* hdl/lagint_pkg.sv */
// lagint_pkg: shared types, constants and fixed-point helpers for the
// lagrange interpolation evaluator; no dependencies
package lagint_pkg;

  localparam int MAX_NODES  = 8;
  localparam int NODE_IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int WIDE_W     = 48;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ENTRY_W    = 2 * DATA_W;

  localparam int DIV_DVS_W  = DATA_W + 1;
  localparam int DIV_DVD_W  = DIV_DVS_W + FRAC_W;
  localparam int DIV_REM_W  = DIV_DVS_W + 1;
  localparam int DIV_STEPS  = DIV_DVD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int NCFG_W     = 4;
  localparam logic [NCFG_W-1:0] NODE_COUNT_RST = 4'd6;

  localparam int IDX_IN_W   = 3;
  localparam int S_TDATA_W  = 72;

  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_J_CHK,
    ST_RD_J,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_T,
    ST_SCL_T,
    ST_MUL_Y,
    ST_ACC,
    ST_NEXT_I,
    ST_DONE
  } lagint_state_e;

  typedef struct packed {
    logic signed [DIV_DVS_W-1:0] num;
    logic signed [DIV_DVS_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quot;
    logic                     sat;
  } sat_res_t;

  // signed divide by 2^16, truncating toward zero
  function automatic logic signed [WIDE_W-1:0] q16_scale(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p[PROD_W-1] ? p + PROD_W'((1 << FRAC_W) - 1) : p;
    return t[PROD_W-1:FRAC_W];
  endfunction

  function automatic sat_res_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_res_t r;
    r.sat  = !((&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1]));
    r.quot = !r.sat ? v[DATA_W-1:0] : (v[WIDE_W-1] ? S32_MIN : S32_MAX);
    return r;
  endfunction

endpackage

/* hdl/lagint_div.sv */
// lagint_div: shared restoring divider, one quotient bit per cycle,
// computes (num * 2^16) / den truncated toward zero and saturated; uses lagint_pkg
module lagint_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  lagint_pkg::div_req_t req_i,
  output logic                 busy_o,
  output logic                 done_o,
  output lagint_pkg::sat_res_t res_o
);

  logic                                   busy_q;
  logic                                   done_q;
  logic [lagint_pkg::DIV_CNT_W-1:0]       cnt_q;
  logic [lagint_pkg::DIV_DVD_W-1:0]       dvd_q;
  logic [lagint_pkg::DIV_REM_W-1:0]       rem_q;
  logic [lagint_pkg::DIV_DVS_W-1:0]       dvs_q;
  logic                                   neg_q;

  logic [lagint_pkg::DIV_DVS_W-1:0]       num_abs;
  logic [lagint_pkg::DIV_DVS_W-1:0]       den_abs;
  logic [lagint_pkg::DIV_REM_W-1:0]       rem_sh;
  logic [lagint_pkg::DIV_REM_W:0]         diff;
  logic                                   qbit;

  assign num_abs = req_i.num[lagint_pkg::DIV_DVS_W-1] ? -req_i.num : req_i.num;
  assign den_abs = req_i.den[lagint_pkg::DIV_DVS_W-1] ? -req_i.den : req_i.den;

  assign rem_sh = {rem_q[lagint_pkg::DIV_REM_W-2:0], dvd_q[lagint_pkg::DIV_DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign qbit   = !diff[lagint_pkg::DIV_REM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= lagint_pkg::DIV_CNT_W'(lagint_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - lagint_pkg::DIV_CNT_W'(1);
        if (cnt_q == lagint_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= {num_abs, {lagint_pkg::FRAC_W{1'b0}}};
      dvs_q <= den_abs;
      rem_q <= '0;
      neg_q <= req_i.num[lagint_pkg::DIV_DVS_W-1] ^ req_i.den[lagint_pkg::DIV_DVS_W-1];
    end else if (busy_q) begin
      rem_q <= qbit ? diff[lagint_pkg::DIV_REM_W-1:0] : rem_sh;
      dvd_q <= {dvd_q[lagint_pkg::DIV_DVD_W-2:0], qbit};
    end
  end

  // sign the magnitude and clamp to 32 bits
  always_comb begin
    if (!neg_q) begin
      res_o.sat  = |dvd_q[lagint_pkg::DIV_DVD_W-1:lagint_pkg::DATA_W-1];
      res_o.quot = res_o.sat ? lagint_pkg::S32_MAX : dvd_q[lagint_pkg::DATA_W-1:0];
    end else begin
      res_o.sat  = (|dvd_q[lagint_pkg::DIV_DVD_W-1:lagint_pkg::DATA_W]) ||
                   (dvd_q[lagint_pkg::DATA_W-1] && (|dvd_q[lagint_pkg::DATA_W-2:0]));
      res_o.quot = res_o.sat ? lagint_pkg::S32_MIN : -dvd_q[lagint_pkg::DATA_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

/* hdl/lagrange_interpolation_eval_core.sv */
// lagrange_interpolation_eval_core: top level, sequencer, node table, shared
// multiplier and output register; uses lagint_pkg and lagint_div
//
// usage
//   s_axis: one beat per item. tuser is the mode (0 load, 1 evaluate). tdata
//   carries node_index, x_value and y_value. a load beat writes the node table
//   slot and gives no result.
//   m_axis: one beat per evaluate item. tdata is the Q16.16 interpolated value,
//   tuser is the fault flag (equal abscissae or saturation).
//   cfg: cfg_we_i writes node_count from cfg_wdata_i; the user writes only while idle, the block does not enforce it.
// evaluation
//   each factor with distinct abscissae is divided in the one 49-step radix-2
//   divider. s_axis_tready_o is low while an evaluate is in flight.
// reset
//   node_count returns to 6, the output register empties; the node table keeps
//   whatever it held and must be loaded before use.
// stall
//   a finished result waits in the output register; loads are still accepted,
//   a further evaluate holds in its last state until the register frees.
module lagrange_interpolation_eval_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // cfg: node_count
  input  logic                             cfg_we_i,
  input  logic [lagint_pkg::NCFG_W-1:0]    cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // node_index [2:0], x_value [34:3], y_value [66:35], zero [71:67]
  input  logic [lagint_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // mode [0]
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // interp_value [31:0]
  output logic [lagint_pkg::DATA_W-1:0]    m_axis_tdata_o,
  // fault [0]
  output logic                             m_axis_tuser_o
);

  localparam int DW = lagint_pkg::DATA_W;

  lagint_pkg::lagint_state_e state_q, state_d;

  logic [lagint_pkg::NCFG_W-1:0]      node_count_q;
  logic [lagint_pkg::CNT_W-1:0]       n_q;
  logic [lagint_pkg::CNT_W-1:0]       i_q;
  logic [lagint_pkg::CNT_W-1:0]       j_q;
  logic [lagint_pkg::CNT_W-1:0]       n_cap;
  logic [lagint_pkg::CNT_W-1:0]       i_next;
  logic [lagint_pkg::CNT_W-1:0]       j_next;

  logic signed [DW-1:0]               q_q;
  logic signed [DW-1:0]               xi_q;
  logic signed [DW-1:0]               yi_q;
  logic signed [DW-1:0]               term_q;
  logic signed [DW-1:0]               fac_q;
  logic signed [DW-1:0]               sum_q;
  logic signed [lagint_pkg::PROD_W-1:0] prod_q;
  logic                               dup_q;
  logic                               fault_q;

  logic                               out_valid_q;
  logic [DW-1:0]                      out_data_q;
  logic                               out_fault_q;

  logic [lagint_pkg::ENTRY_W-1:0]     node_mem [lagint_pkg::MAX_NODES];
  logic [lagint_pkg::ENTRY_W-1:0]     rd_q;
  logic [lagint_pkg::NODE_IDX_W-1:0]  rd_addr;
  logic signed [DW-1:0]               xj;

  logic                               s_fire;
  logic                               in_mode;
  logic [lagint_pkg::IDX_IN_W-1:0]    in_idx;
  logic signed [DW-1:0]               in_x;
  logic signed [DW-1:0]               in_y;

  logic                               out_free;
  logic                               div_start;
  logic                               div_busy;
  logic                               div_done;
  lagint_pkg::div_req_t               div_req;
  lagint_pkg::sat_res_t               div_res;
  lagint_pkg::sat_res_t               scl_res;
  lagint_pkg::sat_res_t               sum_res;
  logic signed [DW:0]                 sum_wide;
  logic signed [DW-1:0]               mul_a;
  logic signed [DW-1:0]               mul_b;

  assign in_mode = s_axis_tuser_i;
  assign in_idx  = s_axis_tdata_i[lagint_pkg::IDX_IN_W-1:0];
  assign in_x    = s_axis_tdata_i[lagint_pkg::IDX_IN_W +: DW];
  assign in_y    = s_axis_tdata_i[lagint_pkg::IDX_IN_W + DW +: DW];
  assign s_fire  = s_axis_tvalid_i && s_axis_tready_o;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign n_cap    = (32'(node_count_q) > lagint_pkg::MAX_NODES) ?
                    lagint_pkg::CNT_W'(lagint_pkg::MAX_NODES) :
                    lagint_pkg::CNT_W'(node_count_q);
  assign i_next   = i_q + lagint_pkg::CNT_W'(1);
  assign j_next   = j_q + lagint_pkg::CNT_W'(1);
  assign xj       = rd_q[DW-1:0];

  assign div_req.num = (DW+1)'(q_q) - (DW+1)'(xj);
  assign div_req.den = (DW+1)'(xi_q) - (DW+1)'(xj);

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= lagint_pkg::NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  // node table, registered read
  always_ff @(posedge clk_i) begin
    if (s_fire && in_mode == lagint_pkg::MODE_LOAD &&
        32'(in_idx) < lagint_pkg::MAX_NODES) begin
      node_mem[lagint_pkg::NODE_IDX_W'(in_idx)] <= {in_y, in_x};
    end
    rd_q <= node_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lagint_pkg::ST_IDLE: begin
        if (s_fire && in_mode == lagint_pkg::MODE_EVAL) begin
          state_d = (n_cap == '0) ? lagint_pkg::ST_DONE : lagint_pkg::ST_RD_I;
        end
      end
      lagint_pkg::ST_RD_I:  state_d = lagint_pkg::ST_LD_I;
      lagint_pkg::ST_LD_I:  state_d = lagint_pkg::ST_J_CHK;
      lagint_pkg::ST_J_CHK: begin
        if (j_q == n_q) begin
          state_d = dup_q ? lagint_pkg::ST_NEXT_I : lagint_pkg::ST_MUL_Y;
        end else if (j_q != i_q) begin
          state_d = lagint_pkg::ST_RD_J;
        end
      end
      lagint_pkg::ST_RD_J:  state_d = lagint_pkg::ST_DIV_GO;
      lagint_pkg::ST_DIV_GO: begin
        state_d = (div_req.den == '0) ? lagint_pkg::ST_J_CHK : lagint_pkg::ST_DIV_WAIT;
      end
      lagint_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = lagint_pkg::ST_MUL_T;
        end
      end
      lagint_pkg::ST_MUL_T:  state_d = lagint_pkg::ST_SCL_T;
      lagint_pkg::ST_SCL_T:  state_d = lagint_pkg::ST_J_CHK;
      lagint_pkg::ST_MUL_Y:  state_d = lagint_pkg::ST_ACC;
      lagint_pkg::ST_ACC:    state_d = lagint_pkg::ST_NEXT_I;
      lagint_pkg::ST_NEXT_I: begin
        state_d = (i_next == n_q) ? lagint_pkg::ST_DONE : lagint_pkg::ST_RD_I;
      end
      lagint_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lagint_pkg::ST_IDLE;
        end
      end
      default:   state_d = lagint_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready_o = (state_q == lagint_pkg::ST_IDLE);
    div_start       = (state_q == lagint_pkg::ST_DIV_GO) && (div_req.den != '0);
    rd_addr         = (state_q == lagint_pkg::ST_RD_I) ?
                      i_q[lagint_pkg::NODE_IDX_W-1:0] :
                      j_q[lagint_pkg::NODE_IDX_W-1:0];
    mul_a           = (state_q == lagint_pkg::ST_MUL_Y) ? yi_q : term_q;
    mul_b           = (state_q == lagint_pkg::ST_MUL_Y) ? term_q : fac_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lagint_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  lagint_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign scl_res  = lagint_pkg::sat32(lagint_pkg::q16_scale(prod_q));
  assign sum_wide = (DW+1)'(sum_q) + (DW+1)'(scl_res.quot);
  assign sum_res  = lagint_pkg::sat32(lagint_pkg::WIDE_W'(sum_wide));

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      dup_q   <= 1'b0;
      fault_q <= 1'b0;
    end else begin
      unique case (state_q)
        lagint_pkg::ST_IDLE: begin
          if (s_fire && in_mode == lagint_pkg::MODE_EVAL) begin
            n_q     <= n_cap;
            i_q     <= '0;
            fault_q <= 1'b0;
          end
        end
        lagint_pkg::ST_LD_I: begin
          j_q   <= '0;
          dup_q <= 1'b0;
        end
        lagint_pkg::ST_J_CHK: begin
          if (j_q == n_q) begin
            fault_q <= fault_q | dup_q;
          end else if (j_q == i_q) begin
            j_q <= j_next;
          end
        end
        lagint_pkg::ST_DIV_GO: begin
          if (div_req.den == '0) begin
            dup_q <= 1'b1;
            j_q   <= j_next;
          end
        end
        lagint_pkg::ST_DIV_WAIT: begin
          if (div_done) begin
            fault_q <= fault_q | div_res.sat;
          end
        end
        lagint_pkg::ST_SCL_T: begin
          fault_q <= fault_q | scl_res.sat;
          j_q     <= j_next;
        end
        lagint_pkg::ST_ACC: begin
          fault_q <= fault_q | scl_res.sat | sum_res.sat;
        end
        lagint_pkg::ST_NEXT_I: begin
          i_q <= i_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lagint_pkg::ST_IDLE: begin
        q_q   <= in_x;
        sum_q <= '0;
      end
      lagint_pkg::ST_LD_I: begin
        xi_q   <= rd_q[DW-1:0];
        yi_q   <= rd_q[lagint_pkg::ENTRY_W-1:DW];
        term_q <= lagint_pkg::ONE_Q16;
      end
      lagint_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          fac_q <= div_res.quot;
        end
      end
      lagint_pkg::ST_MUL_T, lagint_pkg::ST_MUL_Y: begin
        prod_q <= mul_a * mul_b;
      end
      lagint_pkg::ST_SCL_T: begin
        term_q <= scl_res.quot;
      end
      lagint_pkg::ST_ACC: begin
        sum_q <= sum_res.quot;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == lagint_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lagint_pkg::ST_DONE && out_free) begin
      out_data_q  <= sum_q;
      out_fault_q <= fault_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_fault_q;

  a_div_only_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == lagint_pkg::ST_DIV_WAIT)
    else $error("divider busy outside its wait state");

  a_eval_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_mode == lagint_pkg::MODE_EVAL) |=> !s_axis_tready_o)
    else $error("input taken during an evaluate");

  a_j_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lagint_pkg::ST_RD_J) |-> (j_q < n_q && j_q != i_q))
    else $error("factor index out of range or equal to node index");

  a_i_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lagint_pkg::ST_RD_I || state_q == lagint_pkg::ST_ACC) |-> i_q < n_q)
    else $error("node index beyond node count");

endmodule
